FILE: rtl/urta_pkg.sv
// ============================================================================
// Radix-to-ASCII converter package
// Shared widths, register codes, reset values and helper functions for the
// unsigned radix-to-ASCII converter.
// ============================================================================
package urta_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_DIGITS_DEF  = 32;

    localparam int RADIX_W    = 5;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 8;
    localparam int COUNT_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Dividend bits consumed by the divider in one cycle.
    localparam int STEP_BITS = 8;

    localparam logic [RADIX_W-1:0]    RADIX_MIN        = 5'd2;
    localparam logic [RADIX_W-1:0]    RADIX_MAX        = 5'd16;
    localparam logic [RADIX_W-1:0]    RADIX_RESET      = 5'd16;
    localparam logic [CFG_DATA_W-1:0] CHARS_LOW_RESET  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_DATA_W-1:0] CHARS_HIGH_RESET = 64'h6665_6463_6261_3938;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIX      = 2'd0,
        CFG_CHARS_LOW  = 2'd1,
        CFG_CHARS_HIGH = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic               done;
        logic [DIGIT_W-1:0] remainder;
    } t_div_status;

    // Out-of-range radix settings saturate to the nearest legal base.
    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] char_of_digit(
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi,
        input logic [DIGIT_W-1:0]    d
    );
        logic [CFG_DATA_W-1:0] sel;
        sel = d[DIGIT_W-1] ? hi : lo;
        return sel[{d[DIGIT_W-2:0], 3'b000} +: CHAR_W];
    endfunction

endpackage

FILE: rtl/urta_divider.sv
// ============================================================================
// Iterative divide-by-radix unit
// Divides the value by a radix of 2 to 16, eight quotient bits per cycle,
// and reports the quotient and the remainder digit with a done pulse.
// ============================================================================
module urta_divider #(
    parameter int VALUE_WIDTH = urta_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [VALUE_WIDTH-1:0]       i_dividend,
    input  logic [urta_pkg::RADIX_W-1:0] i_divisor,
    output logic [VALUE_WIDTH-1:0]       o_quotient,
    output urta_pkg::t_div_status        o_status
);

    localparam int STEPS      = (VALUE_WIDTH + urta_pkg::STEP_BITS - 1) / urta_pkg::STEP_BITS;
    localparam int PAD_W      = STEPS * urta_pkg::STEP_BITS;
    localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(STEPS - 1);

    logic [PAD_W-1:0]                   r_work;
    logic [PAD_W-1:0]                   n_work;
    logic [urta_pkg::DIGIT_W-1:0]       r_rem;
    logic [urta_pkg::DIGIT_W-1:0]       n_rem;
    logic [urta_pkg::RADIX_W-1:0]       r_divisor;
    logic [STEP_CNT_W-1:0]              r_cnt;
    logic                               r_busy;
    logic                               r_done;
    logic [urta_pkg::STEP_BITS-1:0]     w_qbits;

    always_comb begin
        logic [urta_pkg::DIGIT_W:0] part;
        logic [urta_pkg::DIGIT_W-1:0] rem;
        rem     = r_rem;
        w_qbits = '0;
        for (int i = 0; i < urta_pkg::STEP_BITS; i++) begin
            part = {rem, r_work[PAD_W-1-i]};
            if (part >= r_divisor) begin
                part = part - r_divisor;
                w_qbits[urta_pkg::STEP_BITS-1-i] = 1'b1;
            end
            rem = part[urta_pkg::DIGIT_W-1:0];
        end
        n_rem  = rem;
        n_work = (r_work << urta_pkg::STEP_BITS) | PAD_W'(w_qbits);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work    <= PAD_W'(i_dividend);
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_quotient         = r_work[VALUE_WIDTH-1:0];
    assign o_status.done      = r_done;
    assign o_status.remainder = r_rem;

endmodule

FILE: rtl/urta_digit_stack.sv
// ============================================================================
// Digit stack
// Holds the digits of one value in last-in first-out order, so that digits
// found least significant first leave most significant first.
// ============================================================================
module urta_digit_stack #(
    parameter int MAX_DIGITS = urta_pkg::MAX_DIGITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_push,
    input  logic [urta_pkg::DIGIT_W-1:0] i_digit,
    input  logic                         i_pop,
    output logic [urta_pkg::DIGIT_W-1:0] o_top
);

    logic [urta_pkg::DIGIT_W-1:0] r_stk [MAX_DIGITS];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_stk[0] <= i_digit;
            for (int i = 1; i < MAX_DIGITS; i++) begin
                r_stk[i] <= r_stk[i-1];
            end
        end else if (i_pop) begin
            for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                r_stk[i] <= r_stk[i+1];
            end
        end
    end

    assign o_top = r_stk[0];

endmodule

FILE: rtl/unsigned_radix_to_ascii_core.sv
// Each digit costs one full pass of the divider, and the first character leaves only after
// the last digit is found; then one character leaves per cycle while the output is not
// stalled. A new request is taken once the last character is loaded.
// Reset is synchronous and active low; registers return to radix 16 and "0123456789abcdef".
// ============================================================================
// Unsigned radix-to-ASCII converter
// Splits an unsigned value into digits of a configurable radix with a shared
// iterative divider and emits one table character per digit, most
// significant first, flagging the last one with the digit count.
// ============================================================================
module unsigned_radix_to_ascii_core #(
    parameter int VALUE_WIDTH = urta_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = urta_pkg::MAX_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [urta_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [urta_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [VALUE_WIDTH-1:0]          i_number,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [urta_pkg::CHAR_W-1:0]     o_character,
    output logic                            o_last_digit,
    output logic [urta_pkg::COUNT_W-1:0]    o_digit_count
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    t_state                          r_state;
    logic [urta_pkg::RADIX_W-1:0]    r_radix;
    logic [urta_pkg::CFG_DATA_W-1:0] r_chars_low;
    logic [urta_pkg::CFG_DATA_W-1:0] r_chars_high;
    logic [CNT_W-1:0]                r_n;
    logic [CNT_W-1:0]                n_n;
    logic [CNT_W-1:0]                r_left;
    logic                            r_out_valid;
    logic [urta_pkg::CHAR_W-1:0]     r_char;
    logic                            r_last;
    logic [urta_pkg::COUNT_W-1:0]    r_count;

    logic                            w_accept;
    logic                            w_cfg_accept;
    logic                            w_div_start;
    logic [VALUE_WIDTH-1:0]          w_dividend;
    logic [VALUE_WIDTH-1:0]          w_quotient;
    urta_pkg::t_div_status           w_div_stat;
    logic                            w_div_end;
    logic                            w_push;
    logic                            w_load;
    logic [urta_pkg::DIGIT_W-1:0]    w_top;

    assign o_ready      = (r_state == S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign w_accept     = i_valid && o_ready;
    assign w_cfg_accept = i_cfg_valid && o_cfg_ready;

    assign w_div_end   = (r_state == S_DIV) && w_div_stat.done;
    assign w_div_start = w_accept || (w_div_end && (|w_quotient));
    assign w_dividend  = (r_state == S_IDLE) ? i_number : w_quotient;
    assign w_push      = w_div_end && (r_n < MAX_CNT);
    assign n_n         = w_push ? CNT_W'(r_n + 1'b1) : r_n;
    assign w_load      = (r_state == S_EMIT) && (!r_out_valid || i_ready);

    urta_divider #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (urta_pkg::eff_radix(r_radix)),
        .o_quotient (w_quotient),
        .o_status   (w_div_stat)
    );

    urta_digit_stack #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_push  (w_push),
        .i_digit (w_div_stat.remainder),
        .i_pop   (w_load),
        .o_top   (w_top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_radix      <= urta_pkg::RADIX_RESET;
            r_chars_low  <= urta_pkg::CHARS_LOW_RESET;
            r_chars_high <= urta_pkg::CHARS_HIGH_RESET;
            r_n          <= '0;
            r_left       <= '0;
            r_out_valid  <= 1'b0;
            r_char       <= '0;
            r_last       <= 1'b0;
            r_count      <= '0;
        end else begin
            if (w_cfg_accept) begin
                case (i_cfg_index)
                    urta_pkg::CFG_RADIX: begin
                        r_radix <= i_cfg_data[urta_pkg::RADIX_W-1:0];
                    end
                    urta_pkg::CFG_CHARS_LOW: begin
                        r_chars_low <= i_cfg_data;
                    end
                    urta_pkg::CFG_CHARS_HIGH: begin
                        r_chars_high <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end

            if (r_out_valid && i_ready && !w_load) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_n     <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_end) begin
                        r_n <= n_n;
                        if (!(|w_quotient)) begin
                            r_left  <= n_n;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_out_valid <= 1'b1;
                        r_char      <= urta_pkg::char_of_digit(r_chars_low, r_chars_high,
                                                               w_top);
                        r_last      <= (r_left == ONE_CNT);
                        r_count     <= (r_left == ONE_CNT) ? urta_pkg::COUNT_W'(r_n) : '0;
                        r_left      <= r_left - 1'b1;
                        if (r_left == ONE_CNT) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_character   = r_char;
    assign o_last_digit  = r_last;
    assign o_digit_count = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= MAX_CNT)
        else $error("Digit count exceeds the stack depth.");

    a_emit_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_left != '0) && (r_left <= r_n))
        else $error("Remaining digit count is out of range during emission.");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_DIV))
        else $error("Divider finished outside the divide state.");

    a_hold_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && !i_ready) |=> (r_left == $past(r_left)))
        else $error("A digit was popped while the output was stalled.");

    a_count_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_digit) |-> (o_digit_count == '0))
        else $error("Digit count is nonzero on a digit that is not the last.");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Radix-to-ASCII converter testbench
// Sends unsigned values through the converter under several radix and digit
// table settings, predicts every digit character, last flag and count, and
// compares each emitted digit with the oldest prediction under random
// backpressure on both sides.
// ============================================================================
module tb_top;

    localparam logic [urta_pkg::CFG_IDX_W-1:0]  CFG_UNUSED  = 2'd3;
    localparam logic [urta_pkg::CFG_DATA_W-1:0] HEX_LOW     = 64'h3736_3534_3332_3130;
    localparam logic [urta_pkg::CFG_DATA_W-1:0] HEX_HIGH    = 64'h6665_6463_6261_3938;
    localparam int                              CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [urta_pkg::CHAR_W-1:0]  ch;
        logic                         last;
        logic [urta_pkg::COUNT_W-1:0] count;
    } t_digit;

    class t_digit_scoreboard;
        logic [urta_pkg::RADIX_W-1:0]    radix;
        logic [urta_pkg::CFG_DATA_W-1:0] chars_lo;
        logic [urta_pkg::CFG_DATA_W-1:0] chars_hi;
        t_digit                          expected_q[$];
        int                              errors;

        function new();
            radix    = 5'd16;
            chars_lo = HEX_LOW;
            chars_hi = HEX_HIGH;
            errors   = 0;
        endfunction

        function void apply_reg(logic [urta_pkg::CFG_IDX_W-1:0] idx,
                                logic [urta_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                urta_pkg::CFG_RADIX: begin
                    radix = data[urta_pkg::RADIX_W-1:0];
                end
                urta_pkg::CFG_CHARS_LOW: begin
                    chars_lo = data;
                end
                urta_pkg::CFG_CHARS_HIGH: begin
                    chars_hi = data;
                end
                default: begin
                end
            endcase
        endfunction

        function void note_number(logic [31:0] number);
            logic [31:0]                  rest;
            logic [urta_pkg::RADIX_W-1:0] base;
            logic [urta_pkg::DIGIT_W-1:0] digits [32];
            int                           n;
            t_digit                       d;
            base = (radix < 5'd2) ? 5'd2 : ((radix > 5'd16) ? 5'd16 : radix);
            rest = number;
            n    = 0;
            do begin
                if (n < 32) begin
                    digits[n] = urta_pkg::DIGIT_W'(rest % base);
                    n++;
                end
                rest = rest / base;
            end while (rest != 0);
            for (int k = n - 1; k >= 0; k--) begin
                d.ch    = digits[k][3] ? chars_hi[8*int'(digits[k][2:0]) +: 8]
                                       : chars_lo[8*int'(digits[k][2:0]) +: 8];
                d.last  = (k == 0);
                d.count = (k == 0) ? urta_pkg::COUNT_W'(n) : '0;
                expected_q.push_back(d);
            end
        endfunction

        function void check_digit(logic [urta_pkg::CHAR_W-1:0] ch, logic last,
                                  logic [urta_pkg::COUNT_W-1:0] count);
            t_digit want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected digit: char %h last %b count %0d", ch, last, count);
                end
                return;
            end
            want = expected_q.pop_front();
            if (want.ch !== ch || want.last !== last || want.count !== count) begin
                errors++;
                if (errors <= 10) begin
                    $display({"digit mismatch: expected char %h last %b count %0d, ",
                              "got char %h last %b count %0d"},
                             want.ch, want.last, want.count, ch, last, count);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic [urta_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [urta_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                            i_valid     = 1'b0;
    logic [31:0]                     i_number    = '0;
    logic                            i_ready     = 1'b0;
    logic                            o_cfg_ready;
    logic                            o_ready;
    logic                            o_valid;
    logic [urta_pkg::CHAR_W-1:0]     o_character;
    logic                            o_last_digit;
    logic [urta_pkg::COUNT_W-1:0]    o_digit_count;

    t_digit_scoreboard sb = new();
    int tx_idle_pct = 32;
    int rx_idle_pct = 81;
    int cycle_count = 0;

    unsigned_radix_to_ascii_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_number      (i_number),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_character   (o_character),
        .o_last_digit  (o_last_digit),
        .o_digit_count (o_digit_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_digit(o_character, o_last_digit, o_digit_count);
        end
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic write_reg(logic [urta_pkg::CFG_IDX_W-1:0] idx,
                             logic [urta_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.apply_reg(idx, data);
    endtask

    // Registers change only once every pending digit has been received.
    task automatic load_settings(logic [urta_pkg::CFG_DATA_W-1:0] rdata,
                                 logic [urta_pkg::CFG_DATA_W-1:0] lo,
                                 logic [urta_pkg::CFG_DATA_W-1:0] hi, bit poke_unused);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        write_reg(urta_pkg::CFG_RADIX, rdata);
        write_reg(urta_pkg::CFG_CHARS_LOW, lo);
        write_reg(urta_pkg::CFG_CHARS_HIGH, hi);
        if (poke_unused) begin
            write_reg(CFG_UNUSED, {$urandom, $urandom});
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_number(logic [31:0] v);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid  <= 1'b1;
        i_number <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_number(v);
    endtask

    task automatic run_random(int count);
        logic [urta_pkg::RADIX_W-1:0]    r;
        logic [urta_pkg::CFG_DATA_W-1:0] rdata;
        longint unsigned                 p;
        logic [31:0]                     v;
        int                              base;
        r = ($urandom_range(99) < 70) ? urta_pkg::RADIX_W'($urandom_range(2, 16))
                                      : urta_pkg::RADIX_W'($urandom_range(0, 31));
        rdata = {$urandom, $urandom};
        rdata[urta_pkg::RADIX_W-1:0] = r;
        base = (r < 5'd2) ? 2 : ((r > 5'd16) ? 16 : int'(r));
        load_settings(rdata, ($urandom_range(3) == 0) ? HEX_LOW : {$urandom, $urandom},
                      ($urandom_range(3) == 0) ? HEX_HIGH : {$urandom, $urandom},
                      bit'($urandom_range(1)));
        repeat (count) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    v = $urandom;
                end
                4, 5: begin
                    v = $urandom_range(40);
                end
                6: begin
                    v = $urandom >> $urandom_range(31);
                end
                7, 8: begin
                    p = 1;
                    repeat ($urandom_range(1, 32)) begin
                        if (p * base <= 64'hFFFF_FFFF) begin
                            p = p * base;
                        end
                    end
                    v = 32'(p - $urandom_range(1));
                end
                default: begin
                    v = $urandom_range(1) ? '1 : '0;
                end
            endcase
            send_number(v);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_number(32'd0);
        send_number(32'd1);
        send_number(32'd15);
        send_number(32'd16);
        send_number(32'hFFFF_FFFF);
        send_number(32'h8000_0000);
        send_number(32'h0123_ABCD);

        load_settings(64'h2, HEX_LOW, HEX_HIGH, 1'b0);
        send_number(32'hFFFF_FFFF);
        send_number(32'd0);
        send_number(32'h8000_0000);
        send_number(32'd1);

        load_settings(64'hFFFF_FFFF_FFFF_FFEA, HEX_LOW, HEX_HIGH, 1'b0);
        send_number(32'd4294967295);
        send_number(32'd1000000000);
        send_number(32'd999999999);

        load_settings(64'hFFFF_FFFF_FFFF_FFE0, HEX_LOW, HEX_HIGH, 1'b0);
        send_number(32'd5);
        load_settings(64'h21, HEX_LOW, HEX_HIGH, 1'b0);
        send_number(32'd6);
        load_settings(64'h11, HEX_LOW, HEX_HIGH, 1'b0);
        send_number(32'd255);
        load_settings(64'h1F, HEX_LOW, HEX_HIGH, 1'b0);
        send_number(32'd255);

        load_settings(64'h10, '1, '0, 1'b0);
        send_number(32'hFEDC_BA98);
        send_number(32'h0123_4567);
        load_settings(64'h10, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
        send_number(32'h89AB_CDEF);

        load_settings(64'h3, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        send_number(32'hFFFF_FFFF);
        send_number(32'd0);

        for (int phase = 0; phase < 12; phase++) begin
            if (phase == 4) begin
                tx_idle_pct = 81;
                rx_idle_pct = 32;
            end else if (phase == 8) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            run_random(8);
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule

FILE: filelist.f
rtl/urta_pkg.sv
rtl/urta_divider.sv
rtl/urta_digit_stack.sv
rtl/unsigned_radix_to_ascii_core.sv
test/tb_top.sv
